// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the bracket balance checker
// Holds the bracket characters, verdict codes, the front-to-back command
// type and the byte classifier.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned STACK_DEPTH_DEFAULT = 64;

  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;  // (
  localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;  // {
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;  // <
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;  // )
  localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;  // }
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;  // >

  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_BRACE  = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;
  localparam logic [1:0] KIND_ANGLE  = 2'd3;

  localparam logic [2:0] VERDICT_OK          = 3'd0;
  localparam logic [2:0] VERDICT_CLOSE_EMPTY = 3'd1;
  localparam logic [2:0] VERDICT_WRONG_PAIR  = 3'd2;
  localparam logic [2:0] VERDICT_LEFT_OPEN   = 3'd3;
  localparam logic [2:0] VERDICT_OVERFLOW    = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_OPEN,
    OP_CLOSE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] verdict_code;
    logic       is_balanced;
  } verdict_t;

  // Map one byte to a stack command; absent bytes become no-ops.
  function automatic cmd_t classify(logic [7:0] ch, logic present, logic last);
    cmd_t c;
    c.op   = OP_NONE;
    c.kind = KIND_PAREN;
    c.last = last;
    if (present) begin
      unique case (ch)
        CH_OPEN_PAREN:   begin c.op = OP_OPEN;  c.kind = KIND_PAREN;  end
        CH_OPEN_BRACE:   begin c.op = OP_OPEN;  c.kind = KIND_BRACE;  end
        CH_OPEN_SQUARE:  begin c.op = OP_OPEN;  c.kind = KIND_SQUARE; end
        CH_OPEN_ANGLE:   begin c.op = OP_OPEN;  c.kind = KIND_ANGLE;  end
        CH_CLOSE_PAREN:  begin c.op = OP_CLOSE; c.kind = KIND_PAREN;  end
        CH_CLOSE_BRACE:  begin c.op = OP_CLOSE; c.kind = KIND_BRACE;  end
        CH_CLOSE_SQUARE: begin c.op = OP_CLOSE; c.kind = KIND_SQUARE; end
        CH_CLOSE_ANGLE:  begin c.op = OP_CLOSE; c.kind = KIND_ANGLE;  end
        default:         c.op = OP_NONE;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== sv/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bbc_front.sv =====
// ----------------------------------------------------------------------------
// bbc_front: input side of the bracket balance checker
// Classify each accepted byte and hold it in a two-entry command queue.
// ----------------------------------------------------------------------------
module bbc_front
  import bbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_present_i,
  input  logic       in_last_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= classify(in_char_i, in_present_i, in_last_i);
    end
  end

endmodule

// ===== sv/bbc_back.sv =====
// ----------------------------------------------------------------------------
// bbc_back: stack engine of the bracket balance checker
// Execute one command a cycle unless a held verdict stalls it; register verdicts.
// ----------------------------------------------------------------------------
module bbc_back
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT,
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  cmd_t     cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output verdict_t out_o
);

  // Top of stack lives in a register; entries below it live in the RAM.
  logic [DW-1:0] depth_q, depth_d, depth_nx;
  logic [2:0]    err_q, err_d, err_nx;
  logic [1:0]    top_q, top_d;
  logic          byp_q;
  logic [1:0]    byp_val_q;
  logic          out_valid_q, out_valid_d;
  verdict_t      out_q;

  logic          out_free, exec, active, full;
  logic          do_push, do_pop, ovf, close_empty, wrong;
  logic [1:0]    below, rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] raddr_full;
  logic [2:0]    verdict;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !cmd_i.last || out_free;
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign active      = exec && (err_q == VERDICT_OK);
  assign full        = (depth_q == DW'(STACK_DEPTH));

  assign do_push     = active && (cmd_i.op == OP_OPEN) && !full;
  assign ovf         = active && (cmd_i.op == OP_OPEN) && full;
  assign close_empty = active && (cmd_i.op == OP_CLOSE) && (depth_q == '0);
  assign wrong       = active && (cmd_i.op == OP_CLOSE) && (depth_q != '0)
                       && (top_q != cmd_i.kind);
  assign do_pop      = active && (cmd_i.op == OP_CLOSE) && (depth_q != '0)
                       && (top_q == cmd_i.kind);

  assign below = byp_q ? byp_val_q : rdata;

  always_comb begin
    depth_nx = depth_q;
    if (do_push) begin
      depth_nx = depth_q + DW'(1);
    end else if (do_pop) begin
      depth_nx = depth_q - DW'(1);
    end

    err_nx = err_q;
    if (ovf) begin
      err_nx = VERDICT_OVERFLOW;
    end else if (close_empty) begin
      err_nx = VERDICT_CLOSE_EMPTY;
    end else if (wrong) begin
      err_nx = VERDICT_WRONG_PAIR;
    end

    if (err_nx != VERDICT_OK) begin
      verdict = err_nx;
    end else if (depth_nx != '0) begin
      verdict = VERDICT_LEFT_OPEN;
    end else begin
      verdict = VERDICT_OK;
    end

    top_d = top_q;
    if (do_push) begin
      top_d = cmd_i.kind;
    end else if (do_pop) begin
      top_d = below;
    end

    // A finished expression leaves an empty stack and no error.
    if (exec && cmd_i.last) begin
      depth_d = '0;
      err_d   = VERDICT_OK;
    end else begin
      depth_d = depth_nx;
      err_d   = err_nx;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (exec && cmd_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  // Spill the old top on a push; prefetch the entry below the next top.
  assign ram_we     = do_push && (depth_q != '0);
  assign ram_waddr  = AW'(depth_q - DW'(1));
  assign raddr_full = depth_nx - DW'(2);
  assign ram_raddr  = raddr_full[AW-1:0];

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_q),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= VERDICT_OK;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      err_q       <= err_d;
      byp_q       <= do_push;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    byp_val_q <= top_q;
    if (exec && cmd_i.last) begin
      out_q.verdict_code <= verdict;
      out_q.is_balanced  <= (verdict == VERDICT_OK);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && cmd_i.last |=> depth_q == '0 && err_q == VERDICT_OK && out_valid_q)
    else $error("end of expression did not clear state");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != VERDICT_OK && !(exec && cmd_i.last) |=> $stable(err_q) && $stable(depth_q))
    else $error("state changed after an error");

  // Only a push onto a non-empty stack spills a real top entry.
  a_bypass_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && (depth_q != '0) |=> byp_q && byp_val_q == $past(top_q))
    else $error("bypass not armed after push");

endmodule

// ===== sv/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming checker for nested bracket pairs
// Consumes one expression byte per request and reports one verdict per
// expression, covering the pairs () {} [] and <>.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_axis): one request per byte. tdata carries the byte,
//   tuser says whether the byte is real (0 lets an empty item close the
//   expression), tlast marks the last request of the expression.
//   Output channel (m_axis): one request per expression, sent for the
//   request with tlast set. tdata[0] is 1 for a balanced expression,
//   tdata[3:1] holds the verdict (ok, close on empty, wrong pair, left
//   open, overflow).
//   Throughput: one byte per cycle, except while a held verdict stalls
//   a last byte (see Stall). Each byte costs one push, pop or top compare
//   in the stack engine; the stack below its top sits in a RAM that is
//   prefetched one entry ahead, so pops never wait on a read. A last byte
//   lands in the queue when accepted; the stack engine then runs it into
//   the output register, where its verdict turns valid.
//   Reset: the stack is empty and no error is pending; stack RAM contents
//   are not cleared, nor need they be, and no clearing pass runs.
//   Stall: a held verdict blocks only the last byte of the next expression,
//   which waits at the head of the two-entry queue; one more byte fits
//   behind it, then s_axis_tready drops until the verdict is taken.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tuser,   // [0] byte_present
  input  logic       s_axis_tlast,   // end_of_expression
  // Verdict stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_balanced, [3:1] verdict_code, [7:4] zero
);

  cmd_t     cmd;
  logic     cmd_valid, cmd_ready;
  verdict_t verdict;

  // Front: classify bytes into push/pop/no-op commands and queue them.
  bbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .in_present_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // Back: run the stack, track the sticky error, hold the verdict.
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (verdict)
  );

  // Pack the verdict, lowest field first, zero pad to a byte.
  assign m_axis_tdata = {4'b0000, verdict.verdict_code, verdict.is_balanced};

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the bracket balance checker
// Streams expressions through the byte port, predicts each verdict with a
// private bracket tracker and matches every verdict request against it.
// Covers hand-picked corner cases, the stack limits, a long output stall
// and several phases of random traffic with idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import bbc_pkg::*;

  localparam int unsigned DEPTH          = STACK_DEPTH_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 420;
  localparam int unsigned HOLD_OFF_LEN   = 300;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_OPEN,
    BR_CLOSE
  } bracket_role_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
  } expr_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_byte
  logic       s_axis_tuser = 1'b0;    // [0] byte_present
  logic       s_axis_tlast = 1'b0;    // end_of_expression
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] is_balanced, [3:1] verdict_code

  // Bracket tracker state: mirrors the block's stack, depth and first error
  logic [1:0]  nest_kinds [DEPTH];
  int unsigned nest_depth  = 0;
  logic [2:0]  first_error = VERDICT_OK;
  verdict_t    verdicts_due[$];

  expr_item_t  expr_bytes[$];
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_off_cycles    = 0;
  int unsigned effective_items    = 0;
  int unsigned mismatches         = 0;
  int unsigned quiet_cycles       = 0;

  bracket_balance_checker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] opener(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_OPEN_PAREN;
      KIND_BRACE:  return CH_OPEN_BRACE;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] closer(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_CLOSE_PAREN;
      KIND_BRACE:  return CH_CLOSE_BRACE;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  // Any of the eight bracket characters.
  function automatic logic [7:0] any_bracket();
    logic [2:0] pick;
    pick = 3'($urandom_range(7));
    return pick[2] ? closer(pick[1:0]) : opener(pick[1:0]);
  endfunction

  function automatic bracket_role_e bracket_role(input logic [7:0] ch,
                                                 output logic [1:0] kind);
    kind = KIND_PAREN;
    case (ch)
      CH_OPEN_PAREN:   begin kind = KIND_PAREN;  return BR_OPEN;  end
      CH_OPEN_BRACE:   begin kind = KIND_BRACE;  return BR_OPEN;  end
      CH_OPEN_SQUARE:  begin kind = KIND_SQUARE; return BR_OPEN;  end
      CH_OPEN_ANGLE:   begin kind = KIND_ANGLE;  return BR_OPEN;  end
      CH_CLOSE_PAREN:  begin kind = KIND_PAREN;  return BR_CLOSE; end
      CH_CLOSE_BRACE:  begin kind = KIND_BRACE;  return BR_CLOSE; end
      CH_CLOSE_SQUARE: begin kind = KIND_SQUARE; return BR_CLOSE; end
      CH_CLOSE_ANGLE:  begin kind = KIND_ANGLE;  return BR_CLOSE; end
      default:         return BR_NONE;
    endcase
  endfunction

  // Advance the bracket tracker by one accepted request; queue a verdict on
  // the last byte of an expression and clear the tracker for the next one.
  task automatic update_nesting(input logic [7:0] ch, input logic present,
                                input logic last);
    bracket_role_e role;
    logic [1:0]    kind;
    verdict_t      v;
    role = bracket_role(ch, kind);
    // Bytes after the first error, and absent bytes, change nothing
    if (present && first_error == VERDICT_OK) begin
      if (role == BR_OPEN) begin
        if (nest_depth >= DEPTH) begin
          first_error = VERDICT_OVERFLOW;
        end else begin
          nest_kinds[nest_depth] = kind;
          nest_depth++;
        end
      end else if (role == BR_CLOSE) begin
        if (nest_depth == 0) begin
          first_error = VERDICT_CLOSE_EMPTY;
        end else if (nest_kinds[nest_depth - 1] != kind) begin
          // Leave the stack as it is; the error sticks anyway
          first_error = VERDICT_WRONG_PAIR;
        end else begin
          nest_depth--;
        end
      end
    end
    if (last) begin
      if (first_error != VERDICT_OK) begin
        v.verdict_code = first_error;
      end else if (nest_depth != 0) begin
        v.verdict_code = VERDICT_LEFT_OPEN;
      end else begin
        v.verdict_code = VERDICT_OK;
      end
      v.is_balanced = (v.verdict_code == VERDICT_OK);
      verdicts_due.push_back(v);
      nest_depth  = 0;
      first_error = VERDICT_OK;
    end
  endtask

  // Offer one byte request, with random idle cycles ahead of it, and hold it
  // until the block takes it.
  task automatic send_byte(input logic [7:0] ch, input logic present,
                           input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    update_nesting(ch, present, last);
    effective_items++;
  endtask

  task automatic push_item(input logic [7:0] ch, input logic present);
    expr_item_t it;
    it.ch      = ch;
    it.present = present;
    expr_bytes.push_back(it);
  endtask

  // Send the composed expression, flagging its final byte as the last one.
  task automatic send_expression();
    foreach (expr_bytes[i])
      send_byte(expr_bytes[i].ch, expr_bytes[i].present, i == expr_bytes.size() - 1);
    expr_bytes.delete();
  endtask

  // Build one random expression: mostly well nested with fillers and absent
  // bytes, some of them corrupted, plus deep runs, bracket soup and noise.
  task automatic compose_expression();
    int unsigned style;
    int unsigned ceiling;
    int unsigned roll;
    int unsigned steps;
    logic [1:0]  kind;
    logic [1:0]  open_kinds[$];
    style = $urandom_range(99);
    if (style < 10) begin
      // Raw noise over the whole byte range
      repeat ($urandom_range(12, 1)) push_item(8'($urandom_range(255)), 1'($urandom));
    end else if (style < 16) begin
      repeat ($urandom_range(12, 1)) push_item(any_bracket(), 1'b1);
    end else if (style < 22) begin
      // Deep nesting around the stack limit, now and then past it
      ceiling = $urandom_range(DEPTH + 2, DEPTH - 8);
      repeat (ceiling) begin
        kind = 2'($urandom);
        open_kinds.push_back(kind);
        push_item(opener(kind), 1'b1);
      end
      while (open_kinds.size() != 0 && $urandom_range(99) < 97)
        push_item(closer(open_kinds.pop_back()), 1'b1);
    end else begin
      ceiling = $urandom_range(8, 1);
      steps   = $urandom_range(20, 2);
      repeat (steps) begin
        roll = $urandom_range(99);
        if (roll < 40 && open_kinds.size() < ceiling) begin
          kind = 2'($urandom);
          open_kinds.push_back(kind);
          push_item(opener(kind), 1'b1);
        end else if (roll < 75 && open_kinds.size() != 0) begin
          push_item(closer(open_kinds.pop_back()), 1'b1);
        end else if (roll < 88) begin
          push_item(8'($urandom_range(255)), 1'b1);
        end else begin
          // A bracket that is not really there must not count
          push_item(any_bracket(), 1'b0);
        end
      end
      while (open_kinds.size() != 0) push_item(closer(open_kinds.pop_back()), 1'b1);
      if (style < 45 && expr_bytes.size() != 0) begin
        roll = $urandom_range(2);
        if (roll == 0) begin
          expr_bytes[$urandom_range(expr_bytes.size() - 1)] = {any_bracket(), 1'b1};
        end else if (roll == 1) begin
          expr_bytes.delete($urandom_range(expr_bytes.size() - 1));
        end else begin
          expr_bytes.push_front({closer(2'($urandom)), 1'b1});
        end
      end
    end
    // Close some expressions with an empty tail request
    if (expr_bytes.size() == 0 || $urandom_range(99) < 25)
      push_item(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Every bracket kind, the close-on-empty, wrong-pair and left-open verdicts and the absent-byte cases.
  task automatic test_directed_cases();
    // All four pairs nested, closing on the final byte
    push_item(CH_OPEN_PAREN, 1'b1);   push_item(CH_OPEN_BRACE, 1'b1);
    push_item(CH_OPEN_SQUARE, 1'b1);  push_item(CH_OPEN_ANGLE, 1'b1);
    push_item(CH_CLOSE_ANGLE, 1'b1);  push_item(CH_CLOSE_SQUARE, 1'b1);
    push_item(CH_CLOSE_BRACE, 1'b1);  push_item(CH_CLOSE_PAREN, 1'b1);
    send_expression();
    // Close with nothing open
    push_item(CH_CLOSE_SQUARE, 1'b1);
    send_expression();
    // Wrong pair, then a matching close that must be ignored
    push_item(CH_OPEN_PAREN, 1'b1);   push_item(CH_CLOSE_SQUARE, 1'b1);
    push_item(CH_CLOSE_PAREN, 1'b1);  push_item(8'hFF, 1'b0);
    send_expression();
    // Absent close leaves the bracket open
    push_item(CH_OPEN_SQUARE, 1'b1);  push_item(CH_CLOSE_SQUARE, 1'b0);
    push_item(8'h00, 1'b1);
    send_expression();
    // Empty expression
    push_item(8'h00, 1'b0);
    send_expression();
    // Fillers at both ends of the byte range between a pair
    push_item(CH_OPEN_BRACE, 1'b1);   push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b1);           push_item(CH_CLOSE_BRACE, 1'b1);
    send_expression();
  endtask

  // Fill the stack exactly, overrun it, leave it full at the end, then send a short pair.
  task automatic test_stack_limits();
    logic [1:0] open_kinds[$];
    logic [1:0] kind;
    repeat (DEPTH) begin
      kind = 2'($urandom);
      open_kinds.push_back(kind);
      push_item(opener(kind), 1'b1);
    end
    while (open_kinds.size() != 0) push_item(closer(open_kinds.pop_back()), 1'b1);
    send_expression();
    repeat (DEPTH + 1) push_item(opener(2'($urandom)), 1'b1);
    push_item(CH_CLOSE_ANGLE, 1'b1);
    push_item(8'h41, 1'b0);
    send_expression();
    repeat (DEPTH) push_item(opener(2'($urandom)), 1'b1);
    send_expression();
    push_item(CH_OPEN_ANGLE, 1'b1);   push_item(CH_CLOSE_ANGLE, 1'b1);
    send_expression();
  endtask

  // Block the verdict port for a long stretch while short expressions keep
  // coming, so the block fills up and stalls its byte port.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (30) begin
      push_item(CH_OPEN_PAREN, 1'b1);
      push_item(CH_CLOSE_PAREN, 1'b1);
      send_expression();
    end
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct);
    int unsigned start;
    set_idling(sender_pct, receiver_pct);
    start = effective_items;
    while (effective_items - start < PHASE_ITEMS) begin
      compose_expression();
      send_expression();
    end
  endtask

  // Receiver: hold off while a stall stretch is pending, else stall at random.
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      m_axis_tready   <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Verdict check: match each verdict request against the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: unexpected request, tdata %02h", m_axis_tdata);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (m_axis_tdata[0] !== want.is_balanced) begin
          $error("is_balanced: expected %0d, got %0d", want.is_balanced, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[3:1] !== want.verdict_code) begin
          $error("verdict_code: expected %0d, got %0d", want.verdict_code,
                 m_axis_tdata[3:1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run when no request moves on either port for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_stack_limits();
    test_output_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(14, 14);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    // Give any stray verdict time to show up
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_back.sv
sv/bracket_balance_checker.sv
verif/tb.sv
